// ===== hdl/cmsd_pkg.sv =====
// cmsd_pkg: shared types and constants of the column mean / standard deviation block
// holds the input item and result item structs, engine status and engine states
// no dependencies
`default_nettype none

package cmsd_pkg;

    // fixed field widths of the items
    localparam int SAMPLE_W  = 8;
    localparam int MEAN_W    = 24;
    localparam int SD_W      = 24;
    localparam int GOOD_W    = 17;
    localparam int FRAC_W    = 16;

    // variance scaled by 2^32 stays below 2^47, so its root fits in SD_W bits
    localparam int VAR_FRAC_W = 32;
    localparam int ROOT_IN_W  = 2 * SD_W;

    // missing code after reset
    localparam logic [SAMPLE_W-1:0] MISSING_RESET = 8'd3;

    // one input item
    typedef struct packed {
        logic [SAMPLE_W-1:0] sample_value;
        logic                end_of_column;
    } sample_t;

    // one result item
    typedef struct packed {
        logic [MEAN_W-1:0] mean_value;
        logic [SD_W-1:0]   std_dev;
        logic [GOOD_W-1:0] good_count;
        logic              stats_defined;
    } result_t;

    // engine status toward the top level
    typedef struct packed {
        logic idle;
        logic res_valid;
    } eng_status_t;

    // engine sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV_MEAN,
        ST_DIV_VAR,
        ST_SQRT,
        ST_DONE
    } eng_state_t;

endpackage

`default_nettype wire

// ===== hdl/cmsd_engine.sv =====
// cmsd_engine: end-of-column arithmetic, one bit (or one root digit) per cycle
// shift-add products, a shared restoring divider for mean and variance, a digit root
// depends on cmsd_pkg
`default_nettype none

module cmsd_engine #(
    parameter int CNT_W = 17
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        start,
    input  wire logic [CNT_W-1:0]            op_count,
    input  wire logic [CNT_W+7:0]            op_sum,
    input  wire logic [CNT_W+15:0]           op_sumsq,
    input  wire logic                        res_ready,
    output cmsd_pkg::eng_status_t            status,
    output cmsd_pkg::result_t                result
);

    localparam int SUM_W   = CNT_W + 8;
    localparam int SQ_W    = CNT_W + 16;
    localparam int NUM_W   = 2 * CNT_W + 16;
    localparam int DEN_W   = 2 * CNT_W;
    localparam int DVD_W   = NUM_W + cmsd_pkg::VAR_FRAC_W;
    localparam int STEP_W  = $clog2(DVD_W);
    localparam int QUO_W   = cmsd_pkg::ROOT_IN_W;
    localparam int ROOT_W  = cmsd_pkg::SD_W;
    localparam int SREM_W  = ROOT_W + 2;

    cmsd_pkg::eng_state_t state_reg, state_next;
    logic [STEP_W-1:0]    step_reg, step_next;

    // captured column totals
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [SUM_W-1:0]     sumc_reg, sumc_next;
    logic                 defined_reg, defined_next;

    // shift-add multipliers
    logic [SUM_W-1:0]     mpl_sum_reg, mpl_sum_next;
    logic [SUM_W-1:0]     mpl_cnt_reg, mpl_cnt_next;
    logic [NUM_W-1:0]     mc_sq_reg, mc_sq_next;
    logic [NUM_W-1:0]     mc_sum_reg, mc_sum_next;
    logic [DEN_W-1:0]     mc_cnt_reg, mc_cnt_next;
    logic [NUM_W-1:0]     p1_reg, p1_next;
    logic [NUM_W-1:0]     p2_reg, p2_next;
    logic [DEN_W-1:0]     den_reg, den_next;

    // shared divider
    logic [DVD_W-1:0]     dvd_reg, dvd_next;
    logic [DEN_W-1:0]     dvs_reg, dvs_next;
    logic [DEN_W-1:0]     rem_reg, rem_next;
    logic [QUO_W-1:0]     quo_reg, quo_next;
    logic [cmsd_pkg::MEAN_W-1:0] mean_reg, mean_next;

    // digit root
    logic [QUO_W-1:0]     rad_reg, rad_next;
    logic [SREM_W-1:0]    srem_reg, srem_next;
    logic [ROOT_W-1:0]    root_reg, root_next;

    // divider step: one quotient bit
    logic [DEN_W:0]       rem_sh;
    logic [DEN_W:0]       dvs_ext;
    logic                 div_ge;
    logic [DEN_W-1:0]     rem_step;
    logic [QUO_W-1:0]     quo_step;
    logic [NUM_W-1:0]     num_val;

    assign rem_sh   = {rem_reg, dvd_reg[DVD_W-1]};
    assign dvs_ext  = {1'b0, dvs_reg};
    assign div_ge   = (rem_sh >= dvs_ext);
    assign rem_step = div_ge ? DEN_W'(rem_sh - dvs_ext) : DEN_W'(rem_sh);
    assign quo_step = {quo_reg[QUO_W-2:0], div_ge};
    assign num_val  = (p1_reg >= p2_reg) ? (p1_reg - p2_reg) : '0;

    // root step: one result bit from two radicand bits
    logic [SREM_W+1:0]    srem_sh;
    logic [SREM_W+1:0]    trial;
    logic                 sq_ge;

    assign srem_sh = {srem_reg, rad_reg[QUO_W-1:QUO_W-2]};
    assign trial   = {2'b00, root_reg, 2'b01};
    assign sq_ge   = (srem_sh >= trial);

    // sequencer and datapath next values
    always_comb begin
        state_next   = state_reg;
        step_next    = step_reg;
        count_next   = count_reg;
        sumc_next    = sumc_reg;
        defined_next = defined_reg;
        mpl_sum_next = mpl_sum_reg;
        mpl_cnt_next = mpl_cnt_reg;
        mc_sq_next   = mc_sq_reg;
        mc_sum_next  = mc_sum_reg;
        mc_cnt_next  = mc_cnt_reg;
        p1_next      = p1_reg;
        p2_next      = p2_reg;
        den_next     = den_reg;
        dvd_next     = dvd_reg;
        dvs_next     = dvs_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        mean_next    = mean_reg;
        rad_next     = rad_reg;
        srem_next    = srem_reg;
        root_next    = root_reg;

        case (state_reg)
            cmsd_pkg::ST_IDLE: begin
                if (start) begin
                    count_next   = op_count;
                    sumc_next    = op_sum;
                    defined_next = (op_count >= CNT_W'(2));
                    mpl_sum_next = op_sum;
                    mpl_cnt_next = SUM_W'(op_count);
                    mc_sq_next   = NUM_W'(op_sumsq);
                    mc_sum_next  = NUM_W'(op_sum);
                    mc_cnt_next  = DEN_W'(op_count - CNT_W'(1));
                    p1_next      = '0;
                    p2_next      = '0;
                    den_next     = '0;
                    step_next    = STEP_W'(SUM_W - 1);
                    if (op_count < CNT_W'(2)) begin
                        state_next = cmsd_pkg::ST_DONE;
                    end else begin
                        state_next = cmsd_pkg::ST_MUL;
                    end
                end
            end

            cmsd_pkg::ST_MUL: begin
                // one multiplier bit per cycle for all three products
                if (mpl_cnt_reg[0]) begin
                    p1_next  = p1_reg + mc_sq_reg;
                    den_next = den_reg + mc_cnt_reg;
                end
                if (mpl_sum_reg[0]) begin
                    p2_next = p2_reg + mc_sum_reg;
                end
                mpl_sum_next = mpl_sum_reg >> 1;
                mpl_cnt_next = mpl_cnt_reg >> 1;
                mc_sq_next   = mc_sq_reg << 1;
                mc_sum_next  = mc_sum_reg << 1;
                mc_cnt_next  = mc_cnt_reg << 1;
                step_next    = step_reg - STEP_W'(1);
                if (step_reg == '0) begin
                    // mean: sum * 2^16 / count
                    dvd_next   = DVD_W'({sumc_reg, {cmsd_pkg::FRAC_W{1'b0}}});
                    dvs_next   = DEN_W'(count_reg);
                    rem_next   = '0;
                    quo_next   = '0;
                    step_next  = STEP_W'(DVD_W - 1);
                    state_next = cmsd_pkg::ST_DIV_MEAN;
                end
            end

            cmsd_pkg::ST_DIV_MEAN: begin
                dvd_next  = dvd_reg << 1;
                rem_next  = rem_step;
                quo_next  = quo_step;
                step_next = step_reg - STEP_W'(1);
                if (step_reg == '0) begin
                    // variance: (n*sumsq - sum^2) * 2^32 / (n*(n-1))
                    mean_next  = quo_step[cmsd_pkg::MEAN_W-1:0];
                    dvd_next   = {num_val, {cmsd_pkg::VAR_FRAC_W{1'b0}}};
                    dvs_next   = den_reg;
                    rem_next   = '0;
                    quo_next   = '0;
                    step_next  = STEP_W'(DVD_W - 1);
                    state_next = cmsd_pkg::ST_DIV_VAR;
                end
            end

            cmsd_pkg::ST_DIV_VAR: begin
                dvd_next  = dvd_reg << 1;
                rem_next  = rem_step;
                quo_next  = quo_step;
                step_next = step_reg - STEP_W'(1);
                if (step_reg == '0) begin
                    rad_next   = quo_step;
                    srem_next  = '0;
                    root_next  = '0;
                    step_next  = STEP_W'(ROOT_W - 1);
                    state_next = cmsd_pkg::ST_SQRT;
                end
            end

            cmsd_pkg::ST_SQRT: begin
                rad_next = rad_reg << 2;
                if (sq_ge) begin
                    srem_next = SREM_W'(srem_sh - trial);
                    root_next = {root_reg[ROOT_W-2:0], 1'b1};
                end else begin
                    srem_next = SREM_W'(srem_sh);
                    root_next = {root_reg[ROOT_W-2:0], 1'b0};
                end
                step_next = step_reg - STEP_W'(1);
                if (step_reg == '0) begin
                    state_next = cmsd_pkg::ST_DONE;
                end
            end

            cmsd_pkg::ST_DONE: begin
                if (res_ready) begin
                    state_next = cmsd_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = cmsd_pkg::ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= cmsd_pkg::ST_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        count_reg   <= count_next;
        sumc_reg    <= sumc_next;
        defined_reg <= defined_next;
        mpl_sum_reg <= mpl_sum_next;
        mpl_cnt_reg <= mpl_cnt_next;
        mc_sq_reg   <= mc_sq_next;
        mc_sum_reg  <= mc_sum_next;
        mc_cnt_reg  <= mc_cnt_next;
        p1_reg      <= p1_next;
        p2_reg      <= p2_next;
        den_reg     <= den_next;
        dvd_reg     <= dvd_next;
        dvs_reg     <= dvs_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        mean_reg    <= mean_next;
        rad_reg     <= rad_next;
        srem_reg    <= srem_next;
        root_reg    <= root_next;
    end

    // status and result
    logic [31:0] count_ext;

    assign count_ext = 32'(count_reg);

    assign status.idle      = (state_reg == cmsd_pkg::ST_IDLE);
    assign status.res_valid = (state_reg == cmsd_pkg::ST_DONE);

    assign result.mean_value    = defined_reg ? mean_reg : '0;
    assign result.std_dev       = defined_reg ? root_reg : '0;
    assign result.good_count    = count_ext[cmsd_pkg::GOOD_W-1:0];
    assign result.stats_defined = defined_reg;

`ifndef SYNTHESIS
    // a column with fewer than two good samples finishes at once
    a_short_column: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == cmsd_pkg::ST_IDLE) && start && (op_count < CNT_W'(2))
        |=> (state_reg == cmsd_pkg::ST_DONE))
        else $error("short column did not go straight to done");

    // divider remainder stays below the divisor
    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == cmsd_pkg::ST_DIV_MEAN) || (state_reg == cmsd_pkg::ST_DIV_VAR))
        |-> (rem_reg < dvs_reg))
        else $error("divider remainder reached the divisor");

    // root remainder never exceeds twice the partial root
    a_root_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == cmsd_pkg::ST_SQRT) |-> (srem_reg <= SREM_W'({root_reg, 1'b0})))
        else $error("root remainder out of range");

    // a waiting result holds until taken
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        status.res_valid && !res_ready |=> status.res_valid && $stable(result))
        else $error("result changed while waiting");
`endif

endmodule

`default_nettype wire

// ===== hdl/column_mean_stddev_missing_skip.sv =====
// column_mean_stddev_missing_skip: top level, accumulation, config register, output register
// one item per cycle accumulation while the engine idles; end-of-column math in cmsd_engine
// depends on cmsd_pkg and cmsd_engine
//
// usage:
//   s_valid/s_ready/s_data carry one sample item per cycle; samples equal to the
//   missing code are skipped, good samples past MAX_ROWS in a column are ignored.
//   cfg_valid/cfg_ready/cfg_data write the missing code (always ready, reset 3).
//   m_valid/m_ready/m_data carry one result item per column, caused by the item
//   with end_of_column set (that item's own sample is counted first).
// column end:
//   items without end_of_column are taken every cycle while the engine is idle.
//   after an end_of_column item the bit-serial engine (shift-add products, restoring
//   divider run twice, root one digit a cycle) holds s_ready low until its result
//   moves into the output register and m_valid rises. a column with fewer than two
//   good samples skips the arithmetic and goes straight to the engine's done state.
// reset:
//   clears the sums and count, the engine and m_valid; the missing code returns to 3.
// stall:
//   a result waits in the output register while the next column streams in; if the
//   next column ends first, the engine holds its result and s_ready stays low.
`default_nettype none

module column_mean_stddev_missing_skip #(
    parameter int MAX_ROWS = 65536
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire cmsd_pkg::sample_t                   s_data,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output cmsd_pkg::result_t                        m_data,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [cmsd_pkg::SAMPLE_W-1:0]       cfg_data
);

    localparam int CNT_W = $clog2(MAX_ROWS + 1);
    localparam int SUM_W = CNT_W + 8;
    localparam int SQ_W  = CNT_W + 16;

    logic [cmsd_pkg::SAMPLE_W-1:0] missing_reg, missing_next;
    logic [CNT_W-1:0]              cnt_reg, cnt_next;
    logic [SUM_W-1:0]              sum_reg, sum_next;
    logic [SQ_W-1:0]               sq_reg, sq_next;
    logic                          m_valid_reg, m_valid_next;
    cmsd_pkg::result_t             m_data_reg, m_data_next;

    cmsd_pkg::eng_status_t         eng_status;
    cmsd_pkg::result_t             eng_result;
    logic                          eng_start;
    logic                          res_ready;

    logic                          take;
    logic                          good;
    logic [15:0]                   x_sq;
    logic [CNT_W-1:0]              cnt_add;
    logic [SUM_W-1:0]              sum_add;
    logic [SQ_W-1:0]               sq_add;

    // input handshake
    assign s_ready   = eng_status.idle;
    assign cfg_ready = 1'b1;
    assign take      = s_valid && s_ready;
    assign eng_start = take && s_data.end_of_column;

    // accumulate one good sample
    assign good    = (s_data.sample_value != missing_reg) && (cnt_reg < CNT_W'(MAX_ROWS));
    assign x_sq    = 16'(s_data.sample_value) * 16'(s_data.sample_value);
    assign cnt_add = cnt_reg + CNT_W'(good);
    assign sum_add = good ? (sum_reg + SUM_W'(s_data.sample_value)) : sum_reg;
    assign sq_add  = good ? (sq_reg + SQ_W'(x_sq)) : sq_reg;

    // output register takes the engine result when empty or draining
    assign res_ready = !m_valid_reg || m_ready;

    always_comb begin
        missing_next = missing_reg;
        cnt_next     = cnt_reg;
        sum_next     = sum_reg;
        sq_next      = sq_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;

        if (cfg_valid && cfg_ready) begin
            missing_next = cfg_data;
        end

        // column end clears the sums, the engine captures the totals
        if (take) begin
            if (s_data.end_of_column) begin
                cnt_next = '0;
                sum_next = '0;
                sq_next  = '0;
            end else begin
                cnt_next = cnt_add;
                sum_next = sum_add;
                sq_next  = sq_add;
            end
        end

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (eng_status.res_valid && res_ready) begin
            m_valid_next = 1'b1;
            m_data_next  = eng_result;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            missing_reg <= cmsd_pkg::MISSING_RESET;
            cnt_reg     <= '0;
            sum_reg     <= '0;
            sq_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            missing_reg <= missing_next;
            cnt_reg     <= cnt_next;
            sum_reg     <= sum_next;
            sq_reg      <= sq_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // end-of-column arithmetic
    cmsd_engine #(
        .CNT_W (CNT_W)
    ) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (eng_start),
        .op_count  (cnt_add),
        .op_sum    (sum_add),
        .op_sumsq  (sq_add),
        .res_ready (res_ready),
        .status    (eng_status),
        .result    (eng_result)
    );

`ifndef SYNTHESIS
    // a column end leaves cleared sums for the next column
    a_column_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        take && s_data.end_of_column |=> (cnt_reg == '0) && (sum_reg == '0) && (sq_reg == '0))
        else $error("sums not cleared after column end");

    // the good count saturates at the row limit
    a_count_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(MAX_ROWS))
        else $error("good count passed the row limit");

    // an undefined result carries zero statistics
    a_undefined_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_data_reg.stats_defined
        |-> (m_data_reg.mean_value == '0) && (m_data_reg.std_dev == '0))
        else $error("undefined result with nonzero statistics");
`endif

endmodule

`default_nettype wire

// ===== sim/cmsd_checker.sv =====
`timescale 1ns / 100ps
// cmsd_checker: watches the sample, missing-code and result channels of the column stats block,
// predicts every column result and compares it field by field with what the block gives
// depends on cmsd_pkg
module cmsd_checker #(
    parameter int MAX_ROWS = 65536
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  cmsd_pkg::sample_t             s_data,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  cmsd_pkg::result_t             m_data,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [cmsd_pkg::SAMPLE_W-1:0] cfg_data,
    output int                            mismatches,
    output int                            outstanding
);

    localparam int REPORT_MAX = 10;

    // own copy of the missing code and the column accumulators
    logic [cmsd_pkg::SAMPLE_W-1:0] skip_code = cmsd_pkg::MISSING_RESET;
    bit [63:0]           good_n    = '0;
    bit [63:0]           sum_x     = '0;
    bit [63:0]           sum_x2    = '0;

    // column results still owed by the block, oldest first
    cmsd_pkg::result_t owed_stats[$];

    initial begin
        mismatches  = 0;
        outstanding = 0;
    end

    // largest r with r*r <= v, one bit per step from the top
    function automatic bit [63:0] floor_sqrt(input bit [63:0] v);
        bit [63:0] root;
        bit [63:0] trial;
        root = '0;
        for (int b = 31; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= v) root = trial;
        end
        return root;
    endfunction

    // exact mean and sample std dev in Q8.16 from count, sum and sum of squares
    function automatic cmsd_pkg::result_t column_stats(input bit [63:0] n,
                                                       input bit [63:0] s,
                                                       input bit [63:0] s2);
        cmsd_pkg::result_t r;
        bit [63:0] num;
        bit [63:0] sq;
        bit [63:0] den;
        bit [63:0] var_q;
        r = '0;
        r.good_count = cmsd_pkg::GOOD_W'(n);
        if (n >= 2) begin
            num   = n * s2;
            sq    = s * s;
            num   = (num >= sq) ? num - sq : 64'd0;
            den   = n * (n - 1);
            var_q = ((num / den) << cmsd_pkg::VAR_FRAC_W)
                  + (((num % den) << cmsd_pkg::VAR_FRAC_W) / den);
            r.mean_value    = cmsd_pkg::MEAN_W'((s << cmsd_pkg::FRAC_W) / n);
            r.std_dev       = cmsd_pkg::SD_W'(floor_sqrt(var_q));
            r.stats_defined = 1'b1;
        end
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
                $display("%0t: %s expected %0d got %0d", $time, name, want, got);
        end
    endtask

    // everything is sampled at the rising edge, before the block's own updates land
    always @(posedge aclk) begin : watch
        cmsd_pkg::result_t want;
        if (!aresetn) begin
            skip_code = cmsd_pkg::MISSING_RESET;
            good_n    = '0;
            sum_x     = '0;
            sum_x2    = '0;
            owed_stats.delete();
        end else begin
            // result item against the oldest prediction
            if (m_valid && m_ready) begin
                if (owed_stats.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("%0t: result item with none expected: mean %0d sd %0d n %0d",
                                 $time, m_data.mean_value, m_data.std_dev,
                                 m_data.good_count);
                end else begin
                    want = owed_stats.pop_front();
                    check_field("mean_value", want.mean_value, m_data.mean_value);
                    check_field("std_dev", want.std_dev, m_data.std_dev);
                    check_field("good_count", want.good_count, m_data.good_count);
                    check_field("stats_defined", want.stats_defined, m_data.stats_defined);
                end
            end

            // missing code write
            if (cfg_valid && cfg_ready) skip_code = cfg_data;

            // sample item: accumulate unless missing or the count is saturated
            if (s_valid && s_ready) begin
                if (s_data.sample_value != skip_code && good_n < MAX_ROWS) begin
                    good_n = good_n + 1;
                    sum_x  = sum_x + s_data.sample_value;
                    sum_x2 = sum_x2 + s_data.sample_value * s_data.sample_value;
                end
                if (s_data.end_of_column) begin
                    owed_stats.push_back(column_stats(good_n, sum_x, sum_x2));
                    good_n = '0;
                    sum_x  = '0;
                    sum_x2 = '0;
                end
            end
        end
        outstanding = owed_stats.size();
    end

endmodule

// ===== sim/tb_column_mean_stddev_missing_skip.sv =====
`timescale 1ns / 100ps
// tb_column_mean_stddev_missing_skip: stimulus and verdict for the column stats block
// drives sample items, missing-code writes and result backpressure; checking is in cmsd_checker
// depends on cmsd_pkg, column_mean_stddev_missing_skip and cmsd_checker
module tb_column_mean_stddev_missing_skip;

    localparam int MAX_ROWS       = 65536;
    localparam int ENGINE_LAT     = 240;
    localparam int LONG_HOLD      = 3000;
    localparam int HOLD_AT_RESULT = 2;
    localparam int PHASE_ITEMS    = 200;
    localparam int NUM_PHASES     = 6;
    localparam int CYCLE_LIMIT    = 400_000;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                s_valid   = 1'b0;
    logic                s_ready;
    cmsd_pkg::sample_t   s_data    = '0;
    logic                m_valid;
    logic                m_ready   = 1'b0;
    cmsd_pkg::result_t   m_data;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [cmsd_pkg::SAMPLE_W-1:0] cfg_data  = '0;

    int                  mismatches;
    int                  outstanding;
    int                  cycles    = 0;
    logic [cmsd_pkg::SAMPLE_W-1:0] skip_code = cmsd_pkg::MISSING_RESET;
    int                  send_run  = 0;
    int                  recv_run  = 0;

    // directed columns under the reset missing code, {sample, end_of_column}
    logic [cmsd_pkg::SAMPLE_W:0] directed [25] = '{
        {8'd3, 1'b1},                                   // only a missing sample
        {8'd255, 1'b1},                                 // a single good sample
        {8'd0, 1'b0}, {8'd0, 1'b1},                     // two zeros
        {8'd0, 1'b0}, {8'd255, 1'b1},                   // widest spread
        {8'd255, 1'b0}, {8'd255, 1'b0}, {8'd3, 1'b0}, {8'd255, 1'b1},
        {8'd3, 1'b0}, {8'd7, 1'b0}, {8'd3, 1'b0}, {8'd200, 1'b1},
        {8'd3, 1'b0}, {8'd3, 1'b0}, {8'd3, 1'b1},       // several missing, nothing good
        {8'd1, 1'b0}, {8'd2, 1'b0}, {8'd4, 1'b0}, {8'd8, 1'b0},
        {8'd16, 1'b0}, {8'd32, 1'b0}, {8'd64, 1'b0}, {8'd128, 1'b1}
    };

    always #5 aclk = ~aclk;

    column_mean_stddev_missing_skip #(
        .MAX_ROWS(MAX_ROWS)
    ) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    cmsd_checker #(
        .MAX_ROWS(MAX_ROWS)
    ) u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .outstanding(outstanding)
    );

    // watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // idle cycles before the next item, with occasional back-to-back runs
    function automatic int draw_wait(inout int run_left);
        if (run_left > 0) begin
            run_left--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            run_left = $urandom_range(10, 60);
            return 0;
        end
        return $urandom_range(0, 14);
    endfunction

    // sample value biased toward the missing code and the byte extremes
    function automatic logic [cmsd_pkg::SAMPLE_W-1:0] pick_sample(input bit only_missing);
        int r;
        r = $urandom_range(0, 9);
        if (only_missing || r < 2) return skip_code;
        if (r == 2) return 8'd0;
        if (r == 3) return 8'd255;
        return cmsd_pkg::SAMPLE_W'($urandom_range(0, 255));
    endfunction

    // offer one item; returns at the edge where it is taken, valid still high
    task automatic send_sample(input logic [cmsd_pkg::SAMPLE_W-1:0] value, input logic last,
                               input int gap);
        cmsd_pkg::sample_t item;
        item.sample_value  = value;
        item.end_of_column = last;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
    endtask

    // stop offering, wait for every owed result, then let the engine settle
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (outstanding != 0) @(negedge aclk);
        repeat (ENGINE_LAT) @(posedge aclk);
    endtask

    task automatic write_code(input logic [cmsd_pkg::SAMPLE_W-1:0] code);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= code;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        skip_code = code;
    endtask

    // one column: mostly short, now and then long or entirely missing
    task automatic send_random_column(output int n_items);
        int mode;
        int len;
        mode = $urandom_range(0, 19);
        len  = (mode == 0) ? $urandom_range(100, 400) : $urandom_range(1, 24);
        for (int i = 0; i < len; i++)
            send_sample(pick_sample(mode == 1), i == len - 1, draw_wait(send_run));
        n_items = len;
    endtask

    // sample side and verdict
    initial begin : stimulus
        int                  done_items;
        int                  col_items;
        logic [cmsd_pkg::SAMPLE_W-1:0] phase_code [NUM_PHASES];
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed columns under the reset code
        foreach (directed[i])
            send_sample(directed[i][cmsd_pkg::SAMPLE_W:1], directed[i][0],
                        draw_wait(send_run));

        // random columns under several missing codes, extremes first
        phase_code[0] = 8'd0;
        phase_code[1] = 8'd255;
        for (int p = 2; p < NUM_PHASES; p++)
            phase_code[p] = cmsd_pkg::SAMPLE_W'($urandom_range(0, 255));
        for (int p = 0; p < NUM_PHASES; p++) begin
            write_code(phase_code[p]);
            done_items = 0;
            while (done_items < PHASE_ITEMS) begin
                send_random_column(col_items);
                done_items += col_items;
            end
        end

        wait_drained();
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // result side: random stalls, and one long hold-off so the block backs up
    initial begin : result_sink
        int taken;
        int wait_n;
        taken = 0;
        repeat (12) @(posedge aclk);
        forever begin
            wait_n = (taken == HOLD_AT_RESULT) ? LONG_HOLD : draw_wait(recv_run);
            if (wait_n > 0) begin
                m_ready <= 1'b0;
                repeat (wait_n) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            taken++;
        end
    end

endmodule
